[design/lli_pkg.sv]
// Package for the line intersection block: widths, stage records and helpers.
`timescale 1ns / 1ps
package lli_pkg;

   // Coordinate format (the fraction bits cancel in the quotient).
   localparam int COORD_W = 32;
   localparam int D_W     = COORD_W + 1;          // coordinate difference
   localparam int P_W     = 2 * COORD_W;          // coordinate product
   localparam int CR_W    = P_W + 1;              // cross term of one line
   localparam int CRH_W   = CR_W - COORD_W;       // upper slice of a cross term
   localparam int PP_W    = CRH_W + D_W;          // partial product width
   localparam int DEN_W   = 2 * D_W + 1;          // denominator determinant
   localparam int NUM_W   = CR_W + D_W + 1;       // numerator
   localparam int Q_W     = COORD_W + 1;          // quotient magnitude bits
   localparam int DIV_W   = DEN_W + Q_W;          // remainder datapath
   localparam int REQ_W   = 8 * COORD_W;
   localparam int RSP_W   = ((2 * COORD_W + 7) / 8) * 8;

   // Flags carried in the response tuser.
   localparam int FLAG_PARALLEL = 0;
   localparam int FLAG_OVERFLOW = 1;
   localparam int FLAG_W        = 2;

   typedef struct packed {
      logic signed [D_W-1:0] dxa;
      logic signed [D_W-1:0] dya;
      logic signed [D_W-1:0] dxb;
      logic signed [D_W-1:0] dyb;
      logic signed [P_W-1:0] pa1;
      logic signed [P_W-1:0] pa2;
      logic signed [P_W-1:0] pb1;
      logic signed [P_W-1:0] pb2;
   } s1_type;

   typedef struct packed {
      logic signed [D_W-1:0]   dxa;
      logic signed [D_W-1:0]   dya;
      logic signed [D_W-1:0]   dxb;
      logic signed [D_W-1:0]   dyb;
      logic signed [CR_W-1:0]  cra;
      logic signed [CR_W-1:0]  crb;
      logic signed [2*D_W-1:0] dp1;
      logic signed [2*D_W-1:0] dp2;
   } s2_type;

   // Partial products: x numerator terms then y numerator terms.
   typedef struct packed {
      logic signed [PP_W-1:0]  xah;
      logic signed [PP_W-1:0]  xal;
      logic signed [PP_W-1:0]  xbh;
      logic signed [PP_W-1:0]  xbl;
      logic signed [PP_W-1:0]  yah;
      logic signed [PP_W-1:0]  yal;
      logic signed [PP_W-1:0]  ybh;
      logic signed [PP_W-1:0]  ybl;
      logic signed [DEN_W-1:0] den;
   } s3_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] xa;
      logic signed [NUM_W-1:0] xb;
      logic signed [NUM_W-1:0] ya;
      logic signed [NUM_W-1:0] yb;
      logic signed [DEN_W-1:0] den;
   } s4_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] numx;
      logic signed [NUM_W-1:0] numy;
      logic signed [DEN_W-1:0] den;
   } s5_type;

   typedef struct packed {
      logic [NUM_W-1:0] anx;
      logic [NUM_W-1:0] any;
      logic [DEN_W-1:0] ad;
      logic             negx;
      logic             negy;
      logic             zero;
   } s6_type;

   // One step of the long division pipeline.
   typedef struct packed {
      logic [DIV_W-1:0] remx;
      logic [DIV_W-1:0] remy;
      logic [DEN_W-1:0] ad;
      logic [Q_W-1:0]   qx;
      logic [Q_W-1:0]   qy;
      logic             bigx;
      logic             bigy;
      logic             negx;
      logic             negy;
      logic             zero;
   } div_type;

endpackage

[design/line_line_intersection.sv]
// Pipelined intersection point of two lines given by two points each.
//
//   channel | ports                      | moves
//   --------+----------------------------+----------------------------------------
//   request | req_tvalid/tready/tdata    | a1_x a1_y a2_x a2_y b1_x b1_y b2_x b2_y
//   result  | rsp_tvalid/tready/tdata    | cross_x cross_y; tuser parallel, overflow
//
// One request is taken every cycle while the result is not stalled; its result passes
// through six arithmetic stages, the division entry stage, 33 long division steps (one
// quotient bit each) and the saturation stage.
// Reset is synchronous and clears only the valid bits.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module line_line_intersection (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y from the lowest bit up
   input  logic [lli_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // cross_x, cross_y from the lowest bit up
   output logic [lli_pkg::RSP_W-1:0]   rsp_tdata,
   // parallel, overflow from the lowest bit up
   output logic [lli_pkg::FLAG_W-1:0]  rsp_tuser
);
   import lli_pkg::*;

   localparam int NV = 6 + Q_W + 2;   // valid bits: s1..s6, divider steps, output

   logic                     adv;
   logic [NV-1:0]            vld_ff, vld_in;
   s1_type                   s1_ff, s1_in;
   s2_type                   s2_ff, s2_in;
   s3_type                   s3_ff, s3_in;
   s4_type                   s4_ff, s4_in;
   s5_type                   s5_ff, s5_in;
   s6_type                   s6_ff, s6_in;
   div_type                  div_ff [0:Q_W];
   div_type                  div_in [0:Q_W];
   logic [RSP_W-1:0]         out_ff, out_in;
   logic [FLAG_W-1:0]        flg_ff, flg_in;

   // The whole pipeline moves whenever the output slot is free or being taken.
   assign adv        = !vld_ff[NV-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NV-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = flg_ff;

   assign vld_in = {vld_ff[NV-2:0], req_tvalid};

   // Stage 1: coordinate differences and the products for the cross term of each line.
   always_comb begin
      logic signed [COORD_W-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
      a1x = req_tdata[0*COORD_W +: COORD_W];
      a1y = req_tdata[1*COORD_W +: COORD_W];
      a2x = req_tdata[2*COORD_W +: COORD_W];
      a2y = req_tdata[3*COORD_W +: COORD_W];
      b1x = req_tdata[4*COORD_W +: COORD_W];
      b1y = req_tdata[5*COORD_W +: COORD_W];
      b2x = req_tdata[6*COORD_W +: COORD_W];
      b2y = req_tdata[7*COORD_W +: COORD_W];
      s1_in.dxa = D_W'(a1x) - D_W'(a2x);
      s1_in.dya = D_W'(a1y) - D_W'(a2y);
      s1_in.dxb = D_W'(b1x) - D_W'(b2x);
      s1_in.dyb = D_W'(b1y) - D_W'(b2y);
      s1_in.pa1 = P_W'(a1x) * P_W'(a2y);
      s1_in.pa2 = P_W'(a1y) * P_W'(a2x);
      s1_in.pb1 = P_W'(b1x) * P_W'(b2y);
      s1_in.pb2 = P_W'(b1y) * P_W'(b2x);
   end

   // Stage 2: cross terms and the two products of the denominator.
   always_comb begin
      s2_in.dxa = s1_ff.dxa;
      s2_in.dya = s1_ff.dya;
      s2_in.dxb = s1_ff.dxb;
      s2_in.dyb = s1_ff.dyb;
      s2_in.cra = CR_W'(s1_ff.pa1) - CR_W'(s1_ff.pa2);
      s2_in.crb = CR_W'(s1_ff.pb1) - CR_W'(s1_ff.pb2);
      s2_in.dp1 = (2*D_W)'(s1_ff.dxa) * (2*D_W)'(s1_ff.dyb);
      s2_in.dp2 = (2*D_W)'(s1_ff.dya) * (2*D_W)'(s1_ff.dxb);
   end

   // Stage 3: numerator products split at the lower coordinate slice, and the denominator.
   always_comb begin
      logic signed [PP_W-1:0] cah, cal, cbh, cbl;
      cah = PP_W'($signed(s2_ff.cra[CR_W-1:COORD_W]));
      cal = PP_W'($signed({1'b0, s2_ff.cra[COORD_W-1:0]}));
      cbh = PP_W'($signed(s2_ff.crb[CR_W-1:COORD_W]));
      cbl = PP_W'($signed({1'b0, s2_ff.crb[COORD_W-1:0]}));
      s3_in.xah = cah * PP_W'(s2_ff.dxb);
      s3_in.xal = cal * PP_W'(s2_ff.dxb);
      s3_in.xbh = cbh * PP_W'(s2_ff.dxa);
      s3_in.xbl = cbl * PP_W'(s2_ff.dxa);
      s3_in.yah = cah * PP_W'(s2_ff.dyb);
      s3_in.yal = cal * PP_W'(s2_ff.dyb);
      s3_in.ybh = cbh * PP_W'(s2_ff.dya);
      s3_in.ybl = cbl * PP_W'(s2_ff.dya);
      s3_in.den = DEN_W'(s2_ff.dp1) - DEN_W'(s2_ff.dp2);
   end

   // Stage 4: rejoin the slices of each numerator product.
   always_comb begin
      s4_in.xa  = (NUM_W'(s3_ff.xah) <<< COORD_W) + NUM_W'(s3_ff.xal);
      s4_in.xb  = (NUM_W'(s3_ff.xbh) <<< COORD_W) + NUM_W'(s3_ff.xbl);
      s4_in.ya  = (NUM_W'(s3_ff.yah) <<< COORD_W) + NUM_W'(s3_ff.yal);
      s4_in.yb  = (NUM_W'(s3_ff.ybh) <<< COORD_W) + NUM_W'(s3_ff.ybl);
      s4_in.den = s3_ff.den;
   end

   // Stage 5: numerators.
   always_comb begin
      s5_in.numx = s4_ff.xa - s4_ff.xb;
      s5_in.numy = s4_ff.ya - s4_ff.yb;
      s5_in.den  = s4_ff.den;
   end

   // Stage 6: magnitudes, quotient signs and the zero denominator flag.
   always_comb begin
      s6_in.anx  = s5_ff.numx[NUM_W-1] ? NUM_W'(-s5_ff.numx) : NUM_W'(s5_ff.numx);
      s6_in.any  = s5_ff.numy[NUM_W-1] ? NUM_W'(-s5_ff.numy) : NUM_W'(s5_ff.numy);
      s6_in.ad   = s5_ff.den[DEN_W-1] ? DEN_W'(-s5_ff.den) : DEN_W'(s5_ff.den);
      s6_in.negx = s5_ff.numx[NUM_W-1] ^ s5_ff.den[DEN_W-1];
      s6_in.negy = s5_ff.numy[NUM_W-1] ^ s5_ff.den[DEN_W-1];
      s6_in.zero = (s5_ff.den == '0);
   end

   // Division entry: a quotient that needs more than Q_W bits is flagged here.
   always_comb begin
      logic [DIV_W-1:0] lim;
      lim              = DIV_W'(s6_ff.ad) << Q_W;
      div_in[0].remx   = DIV_W'(s6_ff.anx);
      div_in[0].remy   = DIV_W'(s6_ff.any);
      div_in[0].ad     = s6_ff.ad;
      div_in[0].qx     = '0;
      div_in[0].qy     = '0;
      div_in[0].bigx   = (DIV_W'(s6_ff.anx) >= lim);
      div_in[0].bigy   = (DIV_W'(s6_ff.any) >= lim);
      div_in[0].negx   = s6_ff.negx;
      div_in[0].negy   = s6_ff.negy;
      div_in[0].zero   = s6_ff.zero;
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      always_comb begin
         logic [DIV_W-1:0] sh;
         logic [DIV_W:0]   tx, ty;
         sh = DIV_W'(div_ff[k].ad) << (Q_W - 1 - k);
         tx = {1'b0, div_ff[k].remx} - {1'b0, sh};
         ty = {1'b0, div_ff[k].remy} - {1'b0, sh};
         div_in[k+1]      = div_ff[k];
         if (!tx[DIV_W]) begin
            div_in[k+1].remx            = tx[DIV_W-1:0];
            div_in[k+1].qx[Q_W - 1 - k] = 1'b1;
         end
         if (!ty[DIV_W]) begin
            div_in[k+1].remy            = ty[DIV_W-1:0];
            div_in[k+1].qy[Q_W - 1 - k] = 1'b1;
         end
      end
   end

   // Output stage: signs, saturation and the parallel case.
   always_comb begin
      logic [Q_W-1:0]     lim;
      logic [Q_W-1:0]     mx, my;
      logic               ox, oy;
      logic [COORD_W-1:0] rx, ry;
      div_type            d;
      d   = div_ff[Q_W];
      lim = Q_W'(1) << (COORD_W - 1);
      if (d.negx) begin
         ox = d.bigx || (d.qx > lim);
         mx = ox ? lim : d.qx;
         rx = COORD_W'(~mx + Q_W'(1));
      end else begin
         ox = d.bigx || (d.qx > lim - Q_W'(1));
         mx = ox ? lim - Q_W'(1) : d.qx;
         rx = COORD_W'(mx);
      end
      if (d.negy) begin
         oy = d.bigy || (d.qy > lim);
         my = oy ? lim : d.qy;
         ry = COORD_W'(~my + Q_W'(1));
      end else begin
         oy = d.bigy || (d.qy > lim - Q_W'(1));
         my = oy ? lim - Q_W'(1) : d.qy;
         ry = COORD_W'(my);
      end
      flg_in = '0;
      if (d.zero) begin
         out_in                = '0;
         flg_in[FLAG_PARALLEL] = 1'b1;
      end else begin
         out_in                = RSP_W'({ry, rx});
         flg_in[FLAG_OVERFLOW] = ox || oy;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         out_ff <= out_in;
         flg_ff <= flg_in;
         for (int k = 0; k <= Q_W; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   // A parallel result carries zero coordinates and no overflow.
   a_parallel_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLAG_PARALLEL] |->
         !rsp_tuser[FLAG_OVERFLOW] && rsp_tdata == '0)
      else $error("parallel result with data or overflow");

   // An overflow result has at least one coordinate at a range limit.
   a_overflow_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLAG_OVERFLOW] |->
         rsp_tdata[COORD_W-2:0] == '0 || rsp_tdata[COORD_W-2:0] == '1 ||
         rsp_tdata[2*COORD_W-2:COORD_W] == '0 || rsp_tdata[2*COORD_W-2:COORD_W] == '1)
      else $error("overflow without a saturated coordinate");

   // The pipeline empties on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A request enters exactly when the pipeline advances.
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow the output stall");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the line intersection block.
`timescale 1ns / 1ps
module tb_top;
   import lli_pkg::*;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               par;
      logic               ovf;
   } crossing_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [FLAG_W-1:0]  rsp_tuser;

   crossing_type expected_crossings[$];
   int           mismatch_count;

   line_line_intersection dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Saturating truncated quotient of two wide signed values.
   function automatic logic signed [31:0] saturated_quotient(
         input logic signed [199:0] num, input logic signed [199:0] den,
         inout logic ovf);
      logic signed [199:0] q;
      q = num / den;
      if (q > 200'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -200'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   // Intersection of the two lines packed in one request.
   function automatic crossing_type line_crossing(input logic [REQ_W-1:0] pts);
      logic signed [199:0] c[8];
      logic signed [199:0] dxa, dya, dxb, dyb, cra, crb, numx, numy, den;
      crossing_type r;
      for (int i = 0; i < 8; i++) c[i] = $signed(pts[32*i +: 32]);
      dxa = c[0] - c[2]; dya = c[1] - c[3];
      dxb = c[4] - c[6]; dyb = c[5] - c[7];
      cra = c[0] * c[3] - c[1] * c[2];
      crb = c[4] * c[7] - c[5] * c[6];
      numx = cra * dxb - dxa * crb;
      numy = cra * dyb - dya * crb;
      den = dxa * dyb - dya * dxb;
      r = '0;
      if (den == 0) begin
         r.par = 1'b1;
      end else begin
         r.cx = saturated_quotient(numx, den, r.ovf);
         r.cy = saturated_quotient(numy, den, r.ovf);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("Mismatch on %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   // Send one request after a random gap, recording its expected result.
   // The valid line stays high between back-to-back requests.
   task automatic send_request(input logic [REQ_W-1:0] pts);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pts;
      expected_crossings.push_back(line_crossing(pts));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord(input int spread);
      case (spread)
         0: return $urandom_range(0, 40) - 20;
         1: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
         2: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
         default: return $urandom;
      endcase
   endfunction

   // Result sink: random stalls and comparison with the oldest expectation.
   initial begin
      int stall;
      crossing_type want;
      rsp_tready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_crossings.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], '0);
            end else begin
               want = expected_crossings.pop_front();
               if (rsp_tdata[31:0] !== want.cx)
                  report_mismatch("cross_x", rsp_tdata[31:0], want.cx);
               if (rsp_tdata[63:32] !== want.cy)
                  report_mismatch("cross_y", rsp_tdata[63:32], want.cy);
               if (rsp_tuser[FLAG_PARALLEL] !== want.par)
                  report_mismatch("parallel", rsp_tuser[FLAG_PARALLEL], want.par);
               if (rsp_tuser[FLAG_OVERFLOW] !== want.ovf)
                  report_mismatch("overflow", rsp_tuser[FLAG_OVERFLOW], want.ovf);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Extremes, parallel and degenerate lines, ordinary crossings, saturation.
   task automatic test_directed();
      logic [31:0] mx, mn;
      mx = 32'h7fffffff; mn = 32'h80000000;
      send_request({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      send_request({32'h20000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000,
                    32'h0, 32'h0});
      send_request({32'h10000, 32'h10000, 32'hffff0000, 32'hffff0000,
                    32'h10000, 32'hffff0000, 32'hffff0000, 32'h10000});
      send_request({32'h30000, 32'h30000, 32'h10000, 32'h10000,
                    32'h20000, 32'h20000, 32'h0, 32'h0});
      send_request({32'h1, 32'h7, 32'h5, 32'h5, 32'h2, 32'h3, 32'h1, 32'h1});
      send_request({mx, mn, mn, mx, mx, mx, mn, mn});
      send_request({mn, mn, mx, mx, mn, mx, mx, mn});
      send_request({mx, mx, mx, mx, mn, mn, mn, mn});
      send_request({32'h1, mx, 32'h0, mn, mn, 32'h1, mx, 32'h0});
      send_request({32'h0, 32'h1, 32'h1, 32'h0, mx, 32'h0, mn, 32'h1});
      send_request({32'h1, mn, 32'h0, mx, 32'h0, 32'h1, 32'h1, 32'h0});
      send_request({32'hffffffff, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0,
                    32'hfffffffe, 32'h0});
      send_request({32'h3, 32'h2, 32'h1, 32'h0, 32'h2, 32'h1, 32'h0, 32'h2});
      send_request({mx, 32'h0, mn, 32'h0, 32'h0, mx, 32'h0, mn});
      send_request({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
   endtask

   // Random line pairs of mixed spread, some forced parallel or degenerate.
   task automatic test_random(input int count);
      logic [REQ_W-1:0] pts;
      int spread;
      for (int n = 0; n < count; n++) begin
         spread = $urandom_range(0, 3);
         for (int i = 0; i < 8; i++) pts[32*i +: 32] = random_coord(spread);
         case ($urandom_range(0, 9))
            0: pts[63:0] = pts[127:64];
            1: begin
               pts[223:192] = pts[159:128] + pts[31:0] - pts[95:64];
               pts[255:224] = pts[191:160] + pts[63:32] - pts[127:96];
            end
            default: ;
         endcase
         send_request(pts);
      end
   endtask

   // Hold the sender until the pipeline has drained completely.
   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      while (expected_crossings.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   initial begin
      mismatch_count = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000);
      test_drain_pause();
      test_random(1000);
      req_tvalid <= 1'b0;
      while (expected_crossings.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[line_line_intersection.f]
design/lli_pkg.sv
design/line_line_intersection.sv
tb/tb_top.sv
